@@ rtl/dnle_pkg.sv @@
// dnle_pkg: shared constants and types of the DNS name label encoder.
// No dependencies.
package dnle_pkg;

    localparam int MAX_LABEL = 62;
    localparam int LABEL_AW  = $clog2(MAX_LABEL);
    localparam int CNT_W     = $clog2(MAX_LABEL + 1);

    localparam logic [7:0] DOT_CHAR = 8'h2E;

    typedef struct packed {
        logic                we;
        logic [LABEL_AW-1:0] waddr;
        logic [7:0]          wdata;
        logic [LABEL_AW-1:0] raddr;
    } mem_req_t;

    typedef struct packed {
        logic [CNT_W-1:0] label_count;
        logic             skip;
        logic             emitting;
    } status_t;

endpackage

@@ rtl/dnle_in_if.sv @@
// dnle_in_if: name character channel, valid/ready handshake.
// No dependencies.
interface dnle_in_if;
    logic        valid;
    logic        ready;
    logic        action;
    logic [7:0]  char_byte;
    logic [7:0]  prefix_len;
    logic [15:0] pointer_word;

    modport source (output valid, action, char_byte, prefix_len, pointer_word, input ready);
    modport sink   (input valid, action, char_byte, prefix_len, pointer_word, output ready);
endinterface

@@ rtl/dnle_out_if.sv @@
// dnle_out_if: encoded byte channel, valid/ready handshake.
// No dependencies.
interface dnle_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last_of_name;
    logic       label_too_long;

    modport source (output valid, out_byte, last_of_name, label_too_long, input ready);
    modport sink   (input valid, out_byte, last_of_name, label_too_long, output ready);
endinterface

@@ rtl/dns_name_label_encoder.sv @@
// DNS name label encoder: takes a dotted name one character per word and sends its
// DNS wire form one byte per word. Characters that only extend a label go to the buffer.
// Closing a label replays it from the label buffer, one byte per cycle while the output
// register can take it, through the single registered read port: the length byte, the
// label bytes, and the terminator at end of name; a compression pointer sends two bytes.
// Input is held off during replay; the output register lets the next word in while the
// last byte of a result still waits. Labels beyond 62 characters are truncated and
// flagged. Depends on dnle_pkg, dnle_in_if, dnle_out_if, dnle_label_mem, dnle_ctrl.
module dns_name_label_encoder (
    input  logic       clk,
    input  logic       rst_n,
    dnle_in_if.sink    name_chars,
    dnle_out_if.source wire_bytes
);
    import dnle_pkg::*;

    mem_req_t   mem_req;
    logic [7:0] mem_rdata;
    status_t    status;

    dnle_label_mem u_mem (
        .clk   (clk),
        .req   (mem_req),
        .rdata (mem_rdata)
    );

    dnle_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .name_chars (name_chars),
        .wire_bytes (wire_bytes),
        .mem_req    (mem_req),
        .mem_rdata  (mem_rdata),
        .status     (status)
    );

    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        status.label_count <= CNT_W'(MAX_LABEL))
        else $error("label count past maximum");

    a_last_unflagged: assert property (@(posedge clk) disable iff (!rst_n)
        (wire_bytes.valid && wire_bytes.last_of_name) |-> !wire_bytes.label_too_long)
        else $error("terminator or pointer byte flagged as truncated");

    a_skip_end_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (name_chars.valid && name_chars.ready && name_chars.action && status.skip)
        |=> !status.emitting)
        else $error("end of compressed name produced output");

endmodule

@@ rtl/dnle_label_mem.sv @@
// dnle_label_mem: label byte buffer, one write and one registered read port.
// Depends on dnle_pkg.
module dnle_label_mem (
    input  logic              clk,
    input  dnle_pkg::mem_req_t req,
    output logic [7:0]        rdata
);
    import dnle_pkg::*;

    logic [7:0] mem [MAX_LABEL];
    logic [7:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
        rdata_reg <= mem[req.raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/dnle_ctrl.sv @@
// dnle_ctrl: name sequencer, label flush, pointer insertion and output register.
// Depends on dnle_pkg, dnle_in_if, dnle_out_if.
module dnle_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    dnle_in_if.sink            name_chars,
    dnle_out_if.source         wire_bytes,
    output dnle_pkg::mem_req_t mem_req,
    input  logic [7:0]         mem_rdata,
    output dnle_pkg::status_t  status
);
    import dnle_pkg::*;

    typedef enum logic [1:0] {M_IDLE, M_START, M_LABEL, M_SKIP} name_mode_t;
    typedef enum logic [2:0] {ST_IN, ST_LEN, ST_DATA, ST_TERM, ST_PTRHI, ST_PTRLO} state_t;

    state_t              state_reg, state_next;
    name_mode_t          mode_reg, mode_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [LABEL_AW-1:0] idx_reg, idx_next;
    logic [7:0]          prefix_reg, prefix_next;
    logic [15:0]         ptr_reg, ptr_next;
    logic                ovf_reg, ovf_next;
    logic                term_reg, term_next;
    logic                ovalid_reg, ovalid_next;
    logic [7:0]          obyte_reg, obyte_next;
    logic                olast_reg, olast_next;
    logic                otl_reg, otl_next;

    logic       acc;
    logic       can_push;
    name_mode_t mode_cur;
    logic [7:0] prefix_cur;
    logic [15:0] ptr_cur;
    logic [7:0] prefix_upd;
    logic       finish;

    assign name_chars.ready = (state_reg == ST_IN);
    assign acc      = name_chars.valid && name_chars.ready;
    assign can_push = !ovalid_reg || wire_bytes.ready;

    always_comb
    begin
        state_next  = state_reg;
        mode_next   = mode_reg;
        count_next  = count_reg;
        idx_next    = idx_reg;
        prefix_next = prefix_reg;
        ptr_next    = ptr_reg;
        ovf_next    = ovf_reg;
        term_next   = term_reg;
        ovalid_next = ovalid_reg && !wire_bytes.ready;
        obyte_next  = obyte_reg;
        olast_next  = olast_reg;
        otl_next    = otl_reg;
        finish      = 1'b0;

        mem_req.we    = 1'b0;
        mem_req.waddr = count_reg[LABEL_AW-1:0];
        mem_req.wdata = name_chars.char_byte;

        mode_cur   = mode_reg;
        prefix_cur = prefix_reg;
        ptr_cur    = ptr_reg;
        if (mode_reg == M_IDLE)
        begin
            mode_cur   = M_START;
            prefix_cur = name_chars.prefix_len;
            ptr_cur    = name_chars.pointer_word;
        end
        // prefix after closing the buffered label
        prefix_upd = (prefix_cur > 8'(count_reg)) ? (prefix_cur - 8'(count_reg) - 8'd1) : 8'd0;

        case (state_reg)
            ST_IN:
            begin
                if (acc)
                begin
                    prefix_next = prefix_cur;
                    ptr_next    = ptr_cur;
                    mode_next   = mode_cur;
                    if (name_chars.action)
                    begin
                        mode_next = M_IDLE;
                        if (mode_cur == M_LABEL)
                        begin
                            term_next  = 1'b1;
                            state_next = ST_LEN;
                        end
                        else if (mode_cur != M_SKIP)
                        begin
                            state_next = ST_TERM;
                        end
                    end
                    else
                    begin
                        case (mode_cur)
                            M_START:
                            begin
                                if ((ptr_cur != 16'd0) && (prefix_cur == 8'd0))
                                begin
                                    mode_next  = M_SKIP;
                                    state_next = ST_PTRHI;
                                end
                                else if (name_chars.char_byte == DOT_CHAR)
                                begin
                                    prefix_next = prefix_upd;
                                    term_next   = 1'b0;
                                    state_next  = ST_LEN;
                                end
                                else
                                begin
                                    mem_req.we    = 1'b1;
                                    mem_req.waddr = '0;
                                    count_next    = CNT_W'(1);
                                    ovf_next      = 1'b0;
                                    mode_next     = M_LABEL;
                                end
                            end
                            M_LABEL:
                            begin
                                if (name_chars.char_byte == DOT_CHAR)
                                begin
                                    prefix_next = prefix_upd;
                                    term_next   = 1'b0;
                                    mode_next   = M_START;
                                    state_next  = ST_LEN;
                                end
                                else if (count_reg < CNT_W'(MAX_LABEL))
                                begin
                                    mem_req.we = 1'b1;
                                    count_next = count_reg + CNT_W'(1);
                                end
                                else
                                begin
                                    ovf_next = 1'b1;
                                end
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
            end
            ST_LEN:
            begin
                if (can_push)
                begin
                    ovalid_next = 1'b1;
                    obyte_next  = 8'(count_reg);
                    olast_next  = 1'b0;
                    otl_next    = ovf_reg;
                    idx_next    = '0;
                    if (count_reg == '0)
                    begin
                        finish = 1'b1;
                    end
                    else
                    begin
                        state_next = ST_DATA;
                    end
                end
            end
            ST_DATA:
            begin
                if (can_push)
                begin
                    ovalid_next = 1'b1;
                    obyte_next  = mem_rdata;
                    olast_next  = 1'b0;
                    otl_next    = ovf_reg;
                    if (idx_reg == (count_reg[LABEL_AW-1:0] - LABEL_AW'(1)))
                    begin
                        idx_next = '0;
                        finish   = 1'b1;
                    end
                    else
                    begin
                        idx_next = idx_reg + LABEL_AW'(1);
                    end
                end
            end
            ST_TERM:
            begin
                if (can_push)
                begin
                    ovalid_next = 1'b1;
                    obyte_next  = 8'd0;
                    olast_next  = 1'b1;
                    otl_next    = 1'b0;
                    state_next  = ST_IN;
                end
            end
            ST_PTRHI:
            begin
                if (can_push)
                begin
                    ovalid_next = 1'b1;
                    obyte_next  = ptr_reg[15:8];
                    olast_next  = 1'b0;
                    otl_next    = 1'b0;
                    state_next  = ST_PTRLO;
                end
            end
            ST_PTRLO:
            begin
                if (can_push)
                begin
                    ovalid_next = 1'b1;
                    obyte_next  = ptr_reg[7:0];
                    olast_next  = 1'b1;
                    otl_next    = 1'b0;
                    state_next  = ST_IN;
                end
            end
            default:
            begin
                state_next = ST_IN;
            end
        endcase

        if (finish)
        begin
            count_next = '0;
            ovf_next   = 1'b0;
            state_next = term_reg ? ST_TERM : ST_IN;
        end

        // read one word ahead so mem_rdata matches idx_reg
        mem_req.raddr = idx_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IN;
            mode_reg   <= M_IDLE;
            count_reg  <= '0;
            idx_reg    <= '0;
            prefix_reg <= '0;
            ptr_reg    <= '0;
            ovf_reg    <= 1'b0;
            term_reg   <= 1'b0;
            ovalid_reg <= 1'b0;
            obyte_reg  <= '0;
            olast_reg  <= 1'b0;
            otl_reg    <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            mode_reg   <= mode_next;
            count_reg  <= count_next;
            idx_reg    <= idx_next;
            prefix_reg <= prefix_next;
            ptr_reg    <= ptr_next;
            ovf_reg    <= ovf_next;
            term_reg   <= term_next;
            ovalid_reg <= ovalid_next;
            obyte_reg  <= obyte_next;
            olast_reg  <= olast_next;
            otl_reg    <= otl_next;
        end
    end

    assign wire_bytes.valid          = ovalid_reg;
    assign wire_bytes.out_byte       = obyte_reg;
    assign wire_bytes.last_of_name   = olast_reg;
    assign wire_bytes.label_too_long = otl_reg;

    assign status = '{label_count: count_reg,
                      skip:        (mode_reg == M_SKIP),
                      emitting:    (state_reg != ST_IN)};

endmodule
